@@ design/lfsc_pkg.sv @@
// Shared constants and types for the line-follow speed controller.
package lfsc_pkg;

  // frame receive buffer
  localparam int RX_BUF_SIZE = 32;
  localparam int CNT_W       = 6;
  localparam int SENSORS     = 8;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_ONE = 8'h31;

  // request kinds on the input tuser bit
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // centroid divider: numerator line_gain*16*sum, denominator sensor count
  localparam int NUM_W = 19;
  localparam int DEN_W = 4;

  // sensor center (3.5) in 1/16 units
  localparam logic [5:0] CENTER_X16 = 6'd56;

  typedef enum logic [2:0] {
    CFG_BASE_SPEED   = 3'd0,
    CFG_MIN_SPEED    = 3'd1,
    CFG_MAX_SPEED    = 3'd2,
    CFG_LINE_GAIN    = 3'd3,
    CFG_DIFF_LIMIT   = 3'd4,
    CFG_GYRO_GAIN    = 3'd5,
    CFG_LOSS_TIMEOUT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/lfsc_div.sv @@
// Bit-serial restoring divider for the line centroid quotient.
module lfsc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lfsc_pkg::NUM_W-1:0]   num,
  input  logic [lfsc_pkg::DEN_W-1:0]   den,
  output lfsc_pkg::div_stat_t          stat,
  output logic [lfsc_pkg::NUM_W-1:0]   quo
);

  localparam int CW = $clog2(lfsc_pkg::NUM_W);
  localparam logic [CW-1:0] LAST = CW'(lfsc_pkg::NUM_W - 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CW-1:0]               cnt_r;
  logic [lfsc_pkg::NUM_W-1:0]  quo_r;
  logic [lfsc_pkg::DEN_W-1:0]  rem_r;
  logic [lfsc_pkg::DEN_W-1:0]  den_r;

  logic [lfsc_pkg::DEN_W:0]    trial;
  logic [lfsc_pkg::DEN_W:0]    sub;
  logic                        ge;

  assign trial = {rem_r, quo_r[lfsc_pkg::NUM_W-1]};
  assign sub   = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[lfsc_pkg::NUM_W-2:0], ge};
      rem_r <= ge ? sub[lfsc_pkg::DEN_W-1:0] : trial[lfsc_pkg::DEN_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

@@ design/line_follow_speed_controller.sv @@
// Top level of the line-follow speed controller: frame capture, sequencer, speed math.
//
// Byte transfers (tuser = 0) build an ASCII sensor frame and are absorbed in the cycle
// they arrive, so bytes stream at one per clock. A CR or LF ends the frame; further
// bytes are dropped until a control tick (tuser = 1) consumes it. A tick with no frame
// pending is absorbed with no result. A tick that consumes a frame yields one result:
// when the line is seen it passes prep, divider start, the 19-step bit-serial centroid
// divide, sum, clamp and wheel; when the line is lost the divide is skipped (gyro
// steering only); when the loss timeout stops the wheels it goes from prep to output.
// The input is not ready while a tick is being worked; a finished result sits in
// the output register and the block takes input again as soon as it is loaded there.
// Configuration writes are always taken (cfg_ready is tied high); unknown indexes are
// dropped. No clearing pass is needed after reset.
module line_follow_speed_controller (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // rx_byte[7:0], gyro_rate[23:8], time_ms[55:24]
  input  logic        in_tuser,   // req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // left_cmd[10:0], right_cmd[21:11],
                                  // stopped[22], line_lost[23]
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_SUM,
    ST_CLAMP,
    ST_WHEEL,
    ST_OUT
  } state_t;

  // ---------------- registers ----------------
  state_t                        state_r, state_nxt;

  // configuration
  logic [10:0] base_r, base_nxt;
  logic [10:0] min_r, min_nxt;
  logic [10:0] max_r, max_nxt;
  logic [9:0]  lg_r, lg_nxt;
  logic [10:0] md_r, md_nxt;
  logic [5:0]  gg_r, gg_nxt;
  logic [15:0] tmo_r, tmo_nxt;

  // frame and line state
  logic [lfsc_pkg::SENSORS-1:0]  char_is_one_r, char_is_one_nxt;
  logic [lfsc_pkg::CNT_W-1:0]    byte_count_r, byte_count_nxt;
  logic                          frame_ready_r, frame_ready_nxt;
  logic [lfsc_pkg::SENSORS-1:0]  sensor_r, sensor_nxt;
  logic [31:0]                   lost_since_r, lost_since_nxt;

  // tick payload and working values
  logic signed [15:0]            gyro_r, gyro_nxt;
  logic [31:0]                   now_r, now_nxt;
  logic [lfsc_pkg::NUM_W-1:0]    num_r, num_nxt;
  logic [lfsc_pkg::DEN_W-1:0]    den_r, den_nxt;
  logic [15:0]                   lgk_r, lgk_nxt;
  logic signed [22:0]            gyp_r, gyp_nxt;
  logic                          lost_r, lost_nxt;
  logic signed [24:0]            diff_r, diff_nxt;
  logic signed [16:0]            dcl_r, dcl_nxt;
  logic [10:0]                   lv_r, lv_nxt;
  logic [10:0]                   rv_r, rv_nxt;
  logic                          stop_r, stop_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [10:0]                   out_left_r, out_left_nxt;
  logic [10:0]                   out_right_r, out_right_nxt;
  logic                          out_stop_r, out_stop_nxt;
  logic                          out_lost_r, out_lost_nxt;

  // ---------------- combinational helpers ----------------
  logic                          in_fire;
  logic [7:0]                    rx_byte;
  logic [3:0]                    n_c;
  logic [4:0]                    s_c;
  logic [14:0]                   ls_c;
  logic [31:0]                   elapsed;
  logic signed [24:0]            md16;
  logic signed [17:0]            base16;
  logic signed [17:0]            l16;
  logic signed [17:0]            r16;

  lfsc_pkg::div_stat_t           div_st;
  logic [lfsc_pkg::NUM_W-1:0]    div_q;
  logic                          div_start;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign rx_byte    = in_tdata[7:0];
  assign cfg_ready  = 1'b1;
  assign div_start  = (state_r == ST_START);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_lost_r, out_stop_r, out_right_r, out_left_r};

  lfsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .stat  (div_st),
    .quo   (div_q)
  );

  // round 1/16 value toward zero, then clamp to [min, max]; max wins
  function automatic logic [10:0] wheel(input logic signed [17:0] x,
                                        input logic [10:0] lo,
                                        input logic [10:0] hi);
    logic signed [17:0] adj;
    logic signed [13:0] v;
    adj = x[17] ? (x + 18'sd15) : x;
    v   = 14'(adj >>> 4);
    if (v < $signed({3'b000, lo})) v = $signed({3'b000, lo});
    if (v > $signed({3'b000, hi})) v = $signed({3'b000, hi});
    return v[10:0];
  endfunction

  // active sensor count and index sum
  always_comb begin
    n_c = '0;
    s_c = '0;
    for (int i = 0; i < lfsc_pkg::SENSORS; i++) begin
      if (sensor_r[i]) begin
        n_c = n_c + 4'd1;
        s_c = s_c + 5'(i);
      end
    end
  end

  assign ls_c    = 15'(lg_r) * 15'(s_c);
  assign elapsed = now_r - lost_since_r;
  assign md16    = $signed({10'b0, md_r, 4'b0000});
  assign base16  = $signed({3'b000, base_r, 4'b0000});
  assign l16     = base16 - 18'(dcl_r);
  assign r16     = base16 + 18'(dcl_r);

  // ---------------- next-state logic ----------------
  always_comb begin
    state_nxt       = state_r;
    base_nxt        = base_r;
    min_nxt         = min_r;
    max_nxt         = max_r;
    lg_nxt          = lg_r;
    md_nxt          = md_r;
    gg_nxt          = gg_r;
    tmo_nxt         = tmo_r;
    char_is_one_nxt = char_is_one_r;
    byte_count_nxt  = byte_count_r;
    frame_ready_nxt = frame_ready_r;
    sensor_nxt      = sensor_r;
    lost_since_nxt  = lost_since_r;
    gyro_nxt        = gyro_r;
    now_nxt         = now_r;
    num_nxt         = num_r;
    den_nxt         = den_r;
    lgk_nxt         = lgk_r;
    gyp_nxt         = gyp_r;
    lost_nxt        = lost_r;
    diff_nxt        = diff_r;
    dcl_nxt         = dcl_r;
    lv_nxt          = lv_r;
    rv_nxt          = rv_r;
    stop_nxt        = stop_r;
    out_valid_nxt   = out_valid_r;
    out_left_nxt    = out_left_r;
    out_right_nxt   = out_right_r;
    out_stop_nxt    = out_stop_r;
    out_lost_nxt    = out_lost_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      case (lfsc_pkg::cfg_idx_t'(cfg_index))
        lfsc_pkg::CFG_BASE_SPEED:   base_nxt = cfg_data[10:0];
        lfsc_pkg::CFG_MIN_SPEED:    min_nxt  = cfg_data[10:0];
        lfsc_pkg::CFG_MAX_SPEED:    max_nxt  = cfg_data[10:0];
        lfsc_pkg::CFG_LINE_GAIN:    lg_nxt   = cfg_data[9:0];
        lfsc_pkg::CFG_DIFF_LIMIT:   md_nxt   = cfg_data[10:0];
        lfsc_pkg::CFG_GYRO_GAIN:    gg_nxt   = cfg_data[5:0];
        lfsc_pkg::CFG_LOSS_TIMEOUT: tmo_nxt  = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == lfsc_pkg::REQ_BYTE) begin
            if (!frame_ready_r) begin
              if (byte_count_r < lfsc_pkg::CNT_W'(lfsc_pkg::RX_BUF_SIZE - 1)) begin
                if (byte_count_r < lfsc_pkg::CNT_W'(lfsc_pkg::SENSORS)) begin
                  char_is_one_nxt[byte_count_r[2:0]] = (rx_byte == lfsc_pkg::CHAR_ONE);
                end
                byte_count_nxt = byte_count_r + 1'b1;
              end
              if (rx_byte == lfsc_pkg::CHAR_LF || rx_byte == lfsc_pkg::CHAR_CR) begin
                frame_ready_nxt = 1'b1;
              end
            end
          end else if (frame_ready_r) begin
            // short frame updates only the sensors it covers
            for (int i = 0; i < lfsc_pkg::SENSORS; i++) begin
              if (lfsc_pkg::CNT_W'(i) < byte_count_r) begin
                sensor_nxt[i] = char_is_one_r[i];
              end
            end
            byte_count_nxt  = '0;
            frame_ready_nxt = 1'b0;
            gyro_nxt        = $signed(in_tdata[23:8]);
            now_nxt         = in_tdata[55:24];
            state_nxt       = ST_PREP;
          end
        end
      end

      ST_PREP: begin
        num_nxt  = {ls_c, 4'b0000};
        den_nxt  = n_c;
        lgk_nxt  = 16'(lg_r) * 16'(lfsc_pkg::CENTER_X16);
        gyp_nxt  = 23'($signed({1'b0, gg_r})) * 23'(gyro_r);
        lost_nxt = (n_c == 4'd0);
        stop_nxt = 1'b0;
        if (n_c != 4'd0) begin
          lost_since_nxt = '0;
          state_nxt      = ST_START;
        end else if (lost_since_r == 32'd0) begin
          // first lost tick arms the timer (a zero timestamp leaves it unarmed)
          lost_since_nxt = now_r;
          state_nxt      = ST_SUM;
        end else if (elapsed > {16'b0, tmo_r}) begin
          lv_nxt    = '0;
          rv_nxt    = '0;
          stop_nxt  = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_SUM;
        end
      end

      ST_START: begin
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        if (div_st.done) begin
          state_nxt = ST_SUM;
        end
      end

      ST_SUM: begin
        if (lost_r) begin
          diff_nxt = 25'(gyp_r) + 25'(gyp_r);
        end else begin
          diff_nxt = $signed({6'b0, div_q}) - $signed({9'b0, lgk_r}) + 25'(gyp_r);
        end
        state_nxt = ST_CLAMP;
      end

      ST_CLAMP: begin
        if (diff_r > md16) begin
          dcl_nxt = 17'(md16);
        end else if (diff_r < -md16) begin
          dcl_nxt = 17'(-md16);
        end else begin
          dcl_nxt = 17'(diff_r);
        end
        state_nxt = ST_WHEEL;
      end

      ST_WHEEL: begin
        lv_nxt    = wheel(l16, min_r, max_r);
        rv_nxt    = wheel(r16, min_r, max_r);
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = lv_r;
          out_right_nxt = rv_r;
          out_stop_nxt  = stop_r;
          out_lost_nxt  = lost_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- state and registered outputs ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      base_r        <= 11'd600;
      min_r         <= 11'd100;
      max_r         <= 11'd1000;
      lg_r          <= 10'd150;
      md_r          <= 11'd500;
      gg_r          <= 6'd3;
      tmo_r         <= 16'd300;
      char_is_one_r <= '0;
      byte_count_r  <= '0;
      frame_ready_r <= 1'b0;
      sensor_r      <= '0;
      lost_since_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      base_r        <= base_nxt;
      min_r         <= min_nxt;
      max_r         <= max_nxt;
      lg_r          <= lg_nxt;
      md_r          <= md_nxt;
      gg_r          <= gg_nxt;
      tmo_r         <= tmo_nxt;
      char_is_one_r <= char_is_one_nxt;
      byte_count_r  <= byte_count_nxt;
      frame_ready_r <= frame_ready_nxt;
      sensor_r      <= sensor_nxt;
      lost_since_r  <= lost_since_nxt;
      out_valid_r   <= out_valid_nxt;
      gyro_r        <= gyro_nxt;
      now_r         <= now_nxt;
      num_r         <= num_nxt;
      den_r         <= den_nxt;
      lgk_r         <= lgk_nxt;
      gyp_r         <= gyp_nxt;
      lost_r        <= lost_nxt;
      diff_r        <= diff_nxt;
      dcl_r         <= dcl_nxt;
      lv_r          <= lv_nxt;
      rv_r          <= rv_nxt;
      stop_r        <= stop_nxt;
      out_left_r    <= out_left_nxt;
      out_right_r   <= out_right_nxt;
      out_stop_r    <= out_stop_nxt;
      out_lost_r    <= out_lost_nxt;
    end
  end

  // ---------------- assertions ----------------
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stop_r) |-> (out_left_r == '0 && out_right_r == '0 && out_lost_r))
    else $error("stopped result with nonzero speed or line seen");

  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    frame_ready_r |-> (byte_count_r != '0))
    else $error("frame pending with empty buffer");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= lfsc_pkg::CNT_W'(lfsc_pkg::RX_BUF_SIZE - 1))
    else $error("byte count past buffer limit");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide step");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START) |=> div_st.busy)
    else $error("divider did not start");

endmodule

@@ bench/tb_line_follow_speed_controller.sv @@
// Self-checking testbench for the line-follow speed controller.
module tb_line_follow_speed_controller;

  localparam int SETTLE_CYCLES  = 40;    // idle wait after the last command is back
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transfer
  localparam int MAX_REPORTS    = 10;
  localparam int SEG_ITEMS      = 64;
  localparam int NUM_SEGS       = 6;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [2:0] CFG_SPARE_IDX = 3'd7;  // not a register, must be dropped

  // one speed command, laid out as on out_tdata
  typedef struct packed {
    logic        line_lost;
    logic        stopped;
    logic [10:0] right_cmd;
    logic [10:0] left_cmd;
  } wheel_cmd_t;

  // Tracks the controller state and registers, predicts the speed command of
  // each tick that consumes a frame, and checks commands in order.
  class wheel_cmd_scoreboard;
    logic [10:0] base_spd, min_spd, max_spd, diff_lim;
    logic [9:0]  line_gain;
    logic [5:0]  gyro_gain;
    logic [15:0] loss_tmo;

    logic [7:0]  char_one;
    logic [5:0]  byte_cnt;
    logic        frame_rdy;
    logic [7:0]  sensor_bits;
    logic [31:0] lost_since;

    wheel_cmd_t wheel_cmd_q[$];
    int n_err, n_cmds, n_lost, n_stop;

    function new();
      base_spd = 11'd600; min_spd = 11'd100; max_spd = 11'd1000; line_gain = 10'd150;
      diff_lim = 11'd500; gyro_gain = 6'd3; loss_tmo = 16'd300;
      char_one = '0; byte_cnt = '0; frame_rdy = 1'b0; sensor_bits = '0; lost_since = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        lfsc_pkg::CFG_BASE_SPEED:   base_spd  = data[10:0];
        lfsc_pkg::CFG_MIN_SPEED:    min_spd   = data[10:0];
        lfsc_pkg::CFG_MAX_SPEED:    max_spd   = data[10:0];
        lfsc_pkg::CFG_LINE_GAIN:    line_gain = data[9:0];
        lfsc_pkg::CFG_DIFF_LIMIT:   diff_lim  = data[10:0];
        lfsc_pkg::CFG_GYRO_GAIN:    gyro_gain = data[5:0];
        lfsc_pkg::CFG_LOSS_TIMEOUT: loss_tmo  = data;
        default: ;
      endcase
    endfunction

    function logic [10:0] wheel_speed(longint s16);
      longint v;
      v = s16 / 16;  // truncates toward zero
      if (v < longint'(min_spd)) v = longint'(min_spd);
      if (v > longint'(max_spd)) v = longint'(max_spd);  // max wins over min
      return v[10:0];
    endfunction

    // Returns 1 when the transfer did something (not dropped by the block).
    function bit take_request(logic req, logic [7:0] b, logic signed [15:0] gyro,
                              logic [31:0] now);
      int n, s;
      longint diff16, md16;
      logic [31:0] elapsed;
      wheel_cmd_t cmd;
      if (req == lfsc_pkg::REQ_BYTE) begin
        if (frame_rdy) return 1'b0;
        if (byte_cnt < lfsc_pkg::RX_BUF_SIZE - 1) begin
          if (byte_cnt < lfsc_pkg::SENSORS) char_one[byte_cnt[2:0]] = (b == lfsc_pkg::CHAR_ONE);
          byte_cnt = byte_cnt + 6'd1;
        end
        if (b == lfsc_pkg::CHAR_LF || b == lfsc_pkg::CHAR_CR) frame_rdy = 1'b1;
        return 1'b1;
      end
      if (!frame_rdy) return 1'b0;

      // only positions covered by the frame refresh their sensor
      for (int i = 0; i < lfsc_pkg::SENSORS; i++)
        if (i < byte_cnt) sensor_bits[i] = char_one[i];
      byte_cnt = '0;
      frame_rdy = 1'b0;

      n = 0;
      s = 0;
      for (int i = 0; i < lfsc_pkg::SENSORS; i++)
        if (sensor_bits[i]) begin
          n++;
          s += i;
        end

      if (n != 0) begin
        lost_since = '0;
        diff16 = (longint'(line_gain) * 16 * s) / n
                 - longint'(line_gain) * longint'(lfsc_pkg::CENTER_X16)
                 + longint'(gyro_gain) * longint'(gyro);
      end else begin
        elapsed = now - lost_since;
        if (lost_since == '0) begin
          lost_since = now;  // a zero timestamp leaves the timer disarmed
        end else if (elapsed > {16'd0, loss_tmo}) begin
          cmd = '{line_lost: 1'b1, stopped: 1'b1, right_cmd: '0, left_cmd: '0};
          wheel_cmd_q.push_back(cmd);
          return 1'b1;
        end
        diff16 = 2 * longint'(gyro_gain) * longint'(gyro);
      end

      md16 = longint'(diff_lim) * 16;
      if (diff16 > md16) diff16 = md16;
      if (diff16 < -md16) diff16 = -md16;

      cmd.left_cmd  = wheel_speed(longint'(base_spd) * 16 - diff16);
      cmd.right_cmd = wheel_speed(longint'(base_spd) * 16 + diff16);
      cmd.stopped   = 1'b0;
      cmd.line_lost = (n == 0);
      wheel_cmd_q.push_back(cmd);
      return 1'b1;
    endfunction

    function void check_command(logic [23:0] raw);
      wheel_cmd_t got, want;
      got = raw;
      if (wheel_cmd_q.size() == 0) begin
        n_err++;
        if (n_err <= MAX_REPORTS)
          $display("%0t: command with none expected: L=%0d R=%0d stop=%0b lost=%0b",
                   $time, got.left_cmd, got.right_cmd, got.stopped, got.line_lost);
        return;
      end
      want = wheel_cmd_q.pop_front();
      n_cmds++;
      if (want.line_lost) n_lost++;
      if (want.stopped) n_stop++;
      if (got.left_cmd !== want.left_cmd || got.right_cmd !== want.right_cmd ||
          got.stopped !== want.stopped || got.line_lost !== want.line_lost) begin
        n_err++;
        if (n_err <= MAX_REPORTS) begin
          $display("%0t: mismatch: expected L=%0d R=%0d stop=%0b lost=%0b",
                   $time, want.left_cmd, want.right_cmd, want.stopped, want.line_lost);
          $display("%0t:           got      L=%0d R=%0d stop=%0b lost=%0b",
                   $time, got.left_cmd, got.right_cmd, got.stopped, got.line_lost);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // rx_byte[7:0], gyro_rate[23:8], time_ms[55:24]
  logic        in_tuser = 1'b0; // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // left_cmd[10:0], right_cmd[21:11], stopped, line_lost
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  wheel_cmd_scoreboard sb;
  int src_idle = 0;
  int sink_idle = 0;
  int quiet_cycles = 0;
  int n_xfer = 0;
  int n_used = 0;
  int n_cfg = 0;
  logic [31:0] clock_ms = '0;

  line_follow_speed_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= sink_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_command(out_tdata);
  end

  // ends a hung run: counts cycles in which nothing transfers on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: %0d cycles without a transfer, %0d commands outstanding",
               quiet_cycles, sb.wheel_cmd_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(input logic req, input logic [7:0] b,
                           input logic signed [15:0] gyro, input logic [31:0] now);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {now, gyro, b};
    do @(posedge clk); while (!in_tready);
    n_xfer++;
    if (sb.take_request(req, b, gyro, now)) n_used++;
  endtask

  // unused fields carry random bits so every input bit toggles
  task automatic send_byte(input logic [7:0] b);
    send_item(lfsc_pkg::REQ_BYTE, b, 16'($urandom), $urandom);
  endtask

  task automatic send_tick(input logic signed [15:0] gyro, input logic [31:0] now);
    send_item(lfsc_pkg::REQ_TICK, 8'($urandom), gyro, now);
  endtask

  task automatic send_frame(input string body, input logic [7:0] term);
    for (int i = 0; i < body.len(); i++) send_byte(body[i]);
    send_byte(term);
  endtask

  // hold off input until every command is back and the block has gone quiet
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.wheel_cmd_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic drive_cfg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_regs(input logic [15:0] base, input logic [15:0] lo,
                              input logic [15:0] hi, input logic [15:0] gain,
                              input logic [15:0] mdiff, input logic [15:0] ggain,
                              input logic [15:0] tmo);
    drive_cfg(lfsc_pkg::CFG_BASE_SPEED, base);
    drive_cfg(lfsc_pkg::CFG_MIN_SPEED, lo);
    drive_cfg(lfsc_pkg::CFG_MAX_SPEED, hi);
    drive_cfg(lfsc_pkg::CFG_LINE_GAIN, gain);
    drive_cfg(lfsc_pkg::CFG_DIFF_LIMIT, mdiff);
    drive_cfg(lfsc_pkg::CFG_GYRO_GAIN, ggain);
    drive_cfg(lfsc_pkg::CFG_LOSS_TIMEOUT, tmo);
  endtask

  // mostly steady steps so the loss timer fires; some jumps, some zero stamps
  function automatic logic [31:0] tick_time();
    int r;
    r = $urandom_range(99);
    if (r < 3) clock_ms = '0;
    else if (r < 8) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 250);
    return clock_ms;
  endfunction

  function automatic logic signed [15:0] tick_gyro();
    int g;
    if ($urandom_range(99) < 70) begin
      g = $urandom_range(0, 2000) - 1000;
      return g[15:0];
    end
    return 16'($urandom);
  endfunction

  // a frame of sensor characters, its terminator, maybe stray bytes, then the tick
  task automatic send_random_frame(input bit force_long);
    int len, k;
    bit all_zero;
    logic [7:0] ch;
    len = (force_long || $urandom_range(99) < 8) ? $urandom_range(28, 40)
                                                 : $urandom_range(0, 10);
    all_zero = ($urandom_range(99) < 35);
    for (int i = 0; i < len; i++) begin
      k = $urandom_range(99);
      if (all_zero || k < 45) ch = CHAR_ZERO;
      else if (k < 88) ch = lfsc_pkg::CHAR_ONE;
      else begin
        ch = 8'($urandom);
        while (ch == lfsc_pkg::CHAR_CR || ch == lfsc_pkg::CHAR_LF) ch = 8'($urandom);
      end
      send_byte(ch);
    end
    send_byte($urandom_range(1) ? lfsc_pkg::CHAR_CR : lfsc_pkg::CHAR_LF);
    if ($urandom_range(99) < 15)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    send_tick(tick_gyro(), tick_time());
  endtask

  task automatic program_setting(input int seg);
    case (seg)
      0: program_regs(16'd2047, 16'd0, 16'd2047, 16'd1023, 16'd2047, 16'd63, 16'hFFFF);
      1: begin
        // full 16-bit data exercises the width masking
        program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
        drive_cfg(CFG_SPARE_IDX, 16'($urandom));
      end
      2: program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      3: program_regs(16'($urandom_range(0, 2047)), 16'($urandom_range(1500, 2047)),
                      16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1023)),
                      16'($urandom_range(0, 2047)), 16'($urandom_range(0, 63)),
                      16'($urandom_range(0, 600)));
      4: program_regs(16'($urandom_range(400, 1200)), 16'($urandom_range(0, 300)),
                      16'($urandom_range(1200, 2047)), 16'($urandom_range(0, 1023)),
                      16'($urandom_range(0, 2047)), 16'($urandom_range(0, 63)),
                      16'($urandom_range(0, 500)));
      default: program_regs(16'd600, 16'd100, 16'd1000, 16'd150, 16'd500, 16'd3, 16'd0);
    endcase
  endtask

  initial begin
    int seg_end;
    bit first;
    sb = new();
    src_idle = 26;
    sink_idle = 64;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed part, reset register values
    send_tick(16'sd0, 32'd5);                    // nothing pending: dropped
    send_byte(lfsc_pkg::CHAR_LF);                // empty frame, line lost
    send_tick(16'sh7FFF, 32'd0);                 // zero stamp keeps timer disarmed
    send_byte(lfsc_pkg::CHAR_CR);
    send_tick(16'sh8000, 32'hFFFF_FFFF);         // timer arms at top of range
    send_byte(lfsc_pkg::CHAR_LF);
    send_tick(16'sd100, 32'h0000_011F);          // 288 ms across the wrap
    send_byte(lfsc_pkg::CHAR_CR);
    send_tick(-16'sd100, 32'h0000_012D);         // 302 ms: wheels stop
    send_frame("1", lfsc_pkg::CHAR_LF);          // short frame, sensor 0 only
    send_byte(8'hFF);                            // arrives while pending: dropped
    send_tick(16'sd0, 32'd400);
    send_frame("00000001", lfsc_pkg::CHAR_CR);   // far sensor, full-scale yaw
    send_tick(16'sh7FFF, 32'd500);

    // random part: phase idling pattern changes every two settings
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      drain();
      program_setting(seg);
      src_idle  = (seg < 2) ? 26 : (seg < 4) ? 64 : 0;
      sink_idle = (seg < 2) ? 64 : (seg < 4) ? 26 : 0;
      seg_end = n_used + SEG_ITEMS;
      first = 1'b1;
      while (n_used < seg_end) begin
        if (!first && $urandom_range(99) < 8) begin
          if ($urandom_range(1)) send_byte(8'($urandom));
          else send_tick(16'($urandom), $urandom);
        end else begin
          send_random_frame(first && seg == 0);  // one long frame early on, which may overrun the buffer
          first = 1'b0;
          if ($urandom_range(99) < 10) drain();
        end
      end
    end

    drain();
    sb.n_err += sb.wheel_cmd_q.size();
    $display("Run covered %0d input transfers (%0d acted on) and %0d speed commands,",
             n_xfer, n_used, sb.n_cmds);
    $display("%0d line lost, %0d stopped; %0d register writes over %0d settings; %0d errors.",
             sb.n_lost, sb.n_stop, n_cfg, NUM_SEGS + 1, sb.n_err);
    if (sb.n_err == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
